>>> design/ccfr_pkg.sv
package ccfr_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIZE,
    PH_DATA,
    PH_CRCL,
    PH_CRCH,
    PH_END
  } phase_e;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] ERR_DELIM = 2'd0;
  localparam logic [1:0] ERR_SIZE  = 2'd1;
  localparam logic [1:0] ERR_CRC   = 2'd2;

  localparam logic [7:0]  DELIM_BYTE      = 8'h00;
  localparam logic [7:0]  SIZE_OVERHEAD   = 8'd3;
  localparam logic [7:0]  MAX_LEN_RESET   = 8'd252;
  localparam logic [15:0] CRC_POLY        = 16'h8005;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] code;
    logic [7:0] len;
  } ccfr_res_t;

  // One byte through CRC-16/BUYPASS, MSB first.
  function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/cobs_crc16_frame_receiver.sv
// Receives one link byte per item, strips COBS framing, checks the CRC-16/BUYPASS
// over the size byte and the payload, and returns one result item per decoded
// payload byte, one per accepted frame (with its payload length), and one per
// error; CRC bytes that match, code bytes and idle delimiters give no result.
// An item is accepted in every cycle as long as results are taken; an accepted
// item is held in the input register, the decoder works on it from there, and
// its result is loaded into the output register, from which it is presented.
// A result that is not taken holds the next item in the input register and
// stops further input.
// The configuration register may be written only while no item is in flight.
module cobs_crc16_frame_receiver
  import ccfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] data_byte_o,
  output logic [1:0] error_code_o,
  output logic [7:0] frame_length_o
);

  logic       in_valid_q;
  logic [7:0] rx_byte_q;
  logic [7:0] max_len_q;
  logic       out_valid_q;
  logic [1:0] kind_q;
  logic [7:0] data_q;
  logic [1:0] code_q;
  logic [7:0] len_q;
  logic       advance;
  ccfr_res_t  res;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rx_byte_q <= rx_byte_i;
    end
  end

  ccfr_decoder u_decoder (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (rx_byte_q),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      kind_q <= res.kind;
      data_q <= res.data;
      code_q <= res.code;
      len_q  <= res.len;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign data_byte_o    = data_q;
  assign error_code_o   = code_q;
  assign frame_length_o = len_q;

  // The input register only holds back when a finished result is still waiting.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a pending result");

  // Only the three defined result kinds leave the block.
  a_kind_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_kind_o == KIND_DATA) || (result_kind_o == KIND_OK)
                    || (result_kind_o == KIND_ERR))
    else $error("undefined result kind");

  // Length, error code and data byte are zero unless the kind carries them.
  a_fields_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((result_kind_o == KIND_OK) || (frame_length_o == 8'd0))
                 && ((result_kind_o == KIND_ERR) || (error_code_o == ERR_DELIM))
                 && ((result_kind_o == KIND_DATA) || (data_byte_o == 8'd0)))
    else $error("result field set for the wrong kind");

endmodule

>>> design/ccfr_decoder.sv
module ccfr_decoder
  import ccfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] max_len_i,
  output ccfr_res_t  res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  len_q, len_d;

  logic        is_delim;
  logic [7:0]  cnt_dec;
  logic        cobs_hit;
  logic [7:0]  dec_byte;
  logic [7:0]  size_len;
  logic        size_bad;
  logic [7:0]  left_dec;

  assign is_delim = (byte_i == DELIM_BYTE);
  assign cnt_dec  = cnt_q - 8'd1;
  assign cobs_hit = (cnt_dec == 8'd0);
  assign dec_byte = cobs_hit ? DELIM_BYTE : byte_i;
  assign size_len = byte_i - SIZE_OVERHEAD;
  assign size_bad = (byte_i <= SIZE_OVERHEAD) || (size_len > max_len_i);
  assign left_dec = left_q - 8'd1;

  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      PH_IDLE: begin
        if (!is_delim) phase_d = PH_SIZE;
      end
      PH_SIZE: begin
        phase_d = (is_delim || size_bad) ? PH_IDLE : PH_DATA;
      end
      PH_DATA: begin
        if (is_delim) begin
          phase_d = PH_IDLE;
        end else if (left_dec == 8'd0) begin
          phase_d = PH_CRCL;
        end
      end
      PH_CRCL: begin
        phase_d = (is_delim || (crc_q[7:0] != dec_byte)) ? PH_IDLE : PH_CRCH;
      end
      PH_CRCH: begin
        phase_d = (is_delim || (crc_q[15:8] != dec_byte)) ? PH_IDLE : PH_END;
      end
      PH_END: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    logic clear;
    clear  = 1'b0;
    cnt_d  = cnt_q;
    crc_d  = crc_q;
    left_d = left_q;
    len_d  = len_q;
    res_o  = '0;
    case (phase_q)
      PH_IDLE: begin
        if (!is_delim) cnt_d = byte_i;
      end
      PH_SIZE: begin
        if (is_delim) begin
          clear = 1'b1;
          res_o = '{valid: 1'b1, kind: KIND_ERR, data: 8'd0, code: ERR_DELIM, len: 8'd0};
        end else if (size_bad) begin
          clear = 1'b1;
          res_o = '{valid: 1'b1, kind: KIND_ERR, data: 8'd0, code: ERR_SIZE, len: 8'd0};
        end else begin
          cnt_d  = cnt_dec;
          crc_d  = crc16_add(crc_q, byte_i);
          len_d  = size_len;
          left_d = size_len;
        end
      end
      PH_DATA: begin
        if (is_delim) begin
          clear = 1'b1;
          res_o = '{valid: 1'b1, kind: KIND_ERR, data: 8'd0, code: ERR_DELIM, len: 8'd0};
        end else begin
          cnt_d  = cobs_hit ? byte_i : cnt_dec;
          crc_d  = crc16_add(crc_q, dec_byte);
          left_d = left_dec;
          res_o  = '{valid: 1'b1, kind: KIND_DATA, data: dec_byte, code: ERR_DELIM, len: 8'd0};
        end
      end
      PH_CRCL, PH_CRCH: begin
        if (is_delim) begin
          clear = 1'b1;
          res_o = '{valid: 1'b1, kind: KIND_ERR, data: 8'd0, code: ERR_DELIM, len: 8'd0};
        end else if ((phase_q == PH_CRCL) ? (crc_q[7:0] != dec_byte)
                                          : (crc_q[15:8] != dec_byte)) begin
          clear = 1'b1;
          res_o = '{valid: 1'b1, kind: KIND_ERR, data: 8'd0, code: ERR_CRC, len: 8'd0};
        end else begin
          cnt_d = cobs_hit ? byte_i : cnt_dec;
        end
      end
      PH_END: begin
        clear = 1'b1;
        if (is_delim) begin
          res_o = '{valid: 1'b1, kind: KIND_OK, data: 8'd0, code: ERR_DELIM, len: len_q};
        end else begin
          res_o = '{valid: 1'b1, kind: KIND_ERR, data: 8'd0, code: ERR_SIZE, len: 8'd0};
        end
      end
      default: begin
        clear = 1'b1;
      end
    endcase
    if (clear) begin
      cnt_d  = 8'd0;
      crc_d  = 16'd0;
      left_d = 8'd0;
      len_d  = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= 8'd0;
      crc_q   <= 16'd0;
      left_q  <= 8'd0;
      len_q   <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      left_q  <= left_d;
      len_q   <= len_d;
    end
  end

  // The CRC and the byte counters only run once a frame has started.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (crc_q == 16'd0) && (left_q == 8'd0) && (len_q == 8'd0))
    else $error("decoder state not cleared in idle");

  // The data phase always has payload bytes left to take.
  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (left_q != 8'd0) && (left_q <= len_q))
    else $error("payload counter out of range in data phase");

  // A frame can only be accepted from the end phase.
  a_ok_from_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.kind == KIND_OK)) |-> (phase_q == PH_END) && is_delim)
    else $error("frame accepted outside the end phase");

endmodule
